>>> src/crcfr_pkg.sv
// shared types, codes and the crc16-modbus byte update for the frame receiver
// no dependencies; imported by every module of the receiver
package crcfr_pkg;

    localparam logic [7:0]  START_BYTE_A  = 8'hAA;
    localparam logic [7:0]  START_BYTE_B  = 8'hCC;
    localparam logic [7:0]  END_BYTE      = 8'h55;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
    localparam logic [7:0]  MAX_LEN_RESET = 8'd250;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // configuration register indexes
    localparam logic REG_CRC_CHECK_ENABLE = 1'b0;
    localparam logic REG_MAX_PAYLOAD_LEN  = 1'b1;

    typedef enum logic [6:0] {
        PH_HUNT_A  = 7'b0000001,
        PH_HUNT_B  = 7'b0000010,
        PH_LEN     = 7'b0000100,
        PH_PAYLOAD = 7'b0001000,
        PH_CRC_LO  = 7'b0010000,
        PH_CRC_HI  = 7'b0100000,
        PH_END     = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        EV_PAYLOAD  = 3'd0,
        EV_ACCEPT   = 3'd1,
        EV_CRC_BAD  = 3'd2,
        EV_OVERSIZE = 3'd3,
        EV_NO_END   = 3'd4
    } event_kind_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_length;
        logic [15:0] invalid_count;
    } result_t;

    // reflected crc16, one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_AFTER_A = crc_byte(CRC_INIT, START_BYTE_A);

endpackage

>>> src/crcfr_parser.sv
// frame parser: phase state machine, crc accumulator, length and reject counters
// depends on crcfr_pkg
module crcfr_parser
    import crcfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       line_idle,
    input  logic       crc_check_enable,
    input  logic [7:0] max_payload_len,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [7:0]  byte_cnt_reg, byte_cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [15:0] reject_reg, reject_next;

    logic [15:0] crc_fed;
    logic [7:0]  cnt_inc;
    logic [15:0] reject_inc;

    assign crc_fed    = crc_byte(crc_reg, rx_byte);
    assign cnt_inc    = byte_cnt_reg + 8'd1;
    assign reject_inc = (reject_reg == COUNT_MAX) ? reject_reg : reject_reg + 16'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        byte_cnt_next  = byte_cnt_reg;
        crc_next       = crc_reg;
        crc_low_next   = crc_low_reg;
        reject_next    = reject_reg;
        res_valid      = 1'b0;
        res.event_kind = EV_PAYLOAD;
        res.payload_byte  = 8'h00;
        res.payload_index = 8'h00;

        if (line_idle)
        begin
            phase_next = PH_HUNT_A;
        end
        else
        begin
            case (phase_reg)
                PH_HUNT_B:
                begin
                    if (rx_byte == START_BYTE_B)
                    begin
                        crc_next   = crc_fed;
                        phase_next = PH_LEN;
                    end
                    else if (rx_byte == START_BYTE_A)
                    begin
                        crc_next   = CRC_AFTER_A;
                        phase_next = PH_HUNT_B;
                    end
                    else
                        phase_next = PH_HUNT_A;
                end
                PH_LEN:
                begin
                    frame_len_next = rx_byte;
                    crc_next       = crc_fed;
                    byte_cnt_next  = 8'd0;
                    if (rx_byte > max_payload_len)
                    begin
                        reject_next    = reject_inc;
                        phase_next     = PH_HUNT_A;
                        res_valid      = 1'b1;
                        res.event_kind = EV_OVERSIZE;
                    end
                    else if (rx_byte == 8'd0)
                        phase_next = PH_CRC_LO;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    crc_next      = crc_fed;
                    byte_cnt_next = cnt_inc;
                    if (cnt_inc == frame_len_reg)
                        phase_next = PH_CRC_LO;
                    res_valid         = 1'b1;
                    res.event_kind    = EV_PAYLOAD;
                    res.payload_byte  = rx_byte;
                    res.payload_index = byte_cnt_reg;
                end
                PH_CRC_LO:
                begin
                    crc_low_next = rx_byte;
                    phase_next   = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    // zero exactly when the received crc matches
                    crc_next   = crc_reg ^ {rx_byte, crc_low_reg};
                    phase_next = PH_END;
                end
                PH_END:
                begin
                    phase_next = PH_HUNT_A;
                    res_valid  = 1'b1;
                    if (rx_byte != END_BYTE)
                        res.event_kind = EV_NO_END;
                    else if (crc_check_enable && (crc_reg != 16'h0000))
                    begin
                        reject_next    = reject_inc;
                        res.event_kind = EV_CRC_BAD;
                    end
                    else
                        res.event_kind = EV_ACCEPT;
                end
                default:
                begin
                    if (rx_byte == START_BYTE_A)
                    begin
                        crc_next   = CRC_AFTER_A;
                        phase_next = PH_HUNT_B;
                    end
                    else
                        phase_next = PH_HUNT_A;
                end
            endcase
        end

        res.frame_length  = frame_len_next;
        res.invalid_count = reject_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT_A;
            frame_len_reg <= 8'd0;
            byte_cnt_reg  <= 8'd0;
            crc_reg       <= CRC_INIT;
            crc_low_reg   <= 8'd0;
            reject_reg    <= 16'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            frame_len_reg <= frame_len_next;
            byte_cnt_reg  <= byte_cnt_next;
            crc_reg       <= crc_next;
            crc_low_reg   <= crc_low_next;
            reject_reg    <= reject_next;
        end
    end

endmodule

>>> src/crcfr_out_reg.sv
// result register of the receiver: holds one event until the sink takes it
// depends on crcfr_pkg
module crcfr_out_reg
    import crcfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;

    // free when empty or when the held event leaves this cycle
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            data_reg <= load_data;
    end

endmodule

>>> src/crc_framed_packet_receiver_core.sv
// top level of the crc16-modbus framed packet receiver
// depends on crcfr_pkg, crcfr_parser and crcfr_out_reg
//
// usage
//   s_* carries received serial bytes: s_tdata is the byte, s_tuser flags a
//   line idle event (byte ignored, parser goes back to hunting for 0xAA).
//   m_* carries one event per payload byte and one at each frame end
//   (accepted, crc mismatch, oversize length, end byte missing).
//   wr_en / wr_index / wr_data write the crc check enable (index 0) and the
//   largest accepted payload length (index 1); write only while idle.
//   a byte transfer is held in the input register, is parsed by the
//   byte-wise crc and phase logic, and its event lands in the result register,
//   from which it is shown. one byte per cycle is taken back to back while
//   the sink keeps m_tready high, as the crc byte update is combinational.
//   bytes that cause no event still pass through the input register.
//   when the sink holds m_tready low the result register keeps its event,
//   the input register stalls behind it and s_tready drops.
//   reset empties both registers, returns to hunting, clears the reject
//   count, sets crc check on and the length limit to 250.
module crc_framed_packet_receiver_core
    import crcfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] line_idle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                   // [23:16] frame_length, [39:24] invalid_count
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [7:0]  wr_data
);

    logic       crc_check_enable_reg;
    logic [7:0] max_payload_len_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_idle_reg;

    logic    step;
    logic    out_free;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_check_enable_reg <= 1'b1;
            max_payload_len_reg  <= MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CRC_CHECK_ENABLE: crc_check_enable_reg <= wr_data[0];
                REG_MAX_PAYLOAD_LEN:  max_payload_len_reg  <= wr_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_idle_reg <= s_tuser;
        end
    end

    crcfr_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .rx_byte          (in_byte_reg),
        .line_idle        (in_idle_reg),
        .crc_check_enable (crc_check_enable_reg),
        .max_payload_len  (max_payload_len_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    crcfr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .load_data (res),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.invalid_count, out_data.frame_length,
                      out_data.payload_index, out_data.payload_byte};
    assign m_tuser = out_data.event_kind;

endmodule

>>> tb/crc_framed_packet_receiver_core_test.sv
// self-checking testbench for crc_framed_packet_receiver_core
// predicts events with its own deframer model, pinned directed rows apart; needs crcfr_pkg and the receiver rtl
`timescale 1ns / 100ps

module crc_framed_packet_receiver_core_test;
    import crcfr_pkg::*;

    typedef enum logic [1:0] {
        SEND_RAW,
        SEND_CRC_LO,
        SEND_CRC_HI,
        SEND_CRC_BAD
    } send_kind_t;

    // one directed byte; pinned rows carry a hand-written frame-end event
    typedef struct packed {
        send_kind_t  how;
        logic [7:0]  value;
        logic        idle;
        logic        pinned;
        event_kind_t ev;
        logic [7:0]  flen;
        logic [15:0] cnt;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_tuser = 1'b0;    // [0] line_idle
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [7:0] payload_byte, [15:8] payload_index,
                                    // [23:16] frame_length, [39:24] invalid_count
    logic [2:0]  m_tuser;           // [2:0] event_kind
    logic        wr_en = 1'b0;
    logic        wr_index = 1'b0;
    logic [7:0]  wr_data = 8'h00;

    // deframer state as the testbench sees it
    phase_t      rx_phase = PH_HUNT_A;
    logic [7:0]  frame_len = 8'h00;
    logic [7:0]  pay_count = 8'h00;
    logic [15:0] crc_run = CRC_INIT;
    logic [7:0]  crc_lo_byte = 8'h00;
    logic [15:0] reject_total = 16'h0000;
    logic        check_crc = 1'b1;
    logic [7:0]  len_limit = MAX_LEN_RESET;

    result_t     events_due[$];
    logic        pin_due = 1'b0;
    result_t     pin_event;
    int unsigned items_done = 0;
    int          mismatches = 0;
    bit          steady = 1'b0;

    logic        phase_crc [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    logic [7:0]  phase_len [6] = '{8'd250, 8'd250, 8'd0, 8'd5, 8'd37, 8'd250};

    dir_row_t dir_rows [27] = '{
        '{SEND_RAW,     8'hAA, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'h12, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'hAA, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'hAA, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'hCC, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'hFB, 1'b0, 1'b1, EV_OVERSIZE, 8'hFB, 16'h0001},
        '{SEND_RAW,     8'hAA, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'hCC, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'h00, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_CRC_LO,  8'h00, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_CRC_HI,  8'h00, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'h55, 1'b0, 1'b1, EV_ACCEPT,   8'h00, 16'h0001},
        '{SEND_RAW,     8'hAA, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'hCC, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'h01, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'hFF, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_CRC_LO,  8'h00, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_CRC_BAD, 8'h00, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'h55, 1'b0, 1'b1, EV_CRC_BAD,  8'h01, 16'h0002},
        '{SEND_RAW,     8'hAA, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'h55, 1'b1, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'hAA, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'hCC, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'h00, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_CRC_LO,  8'h00, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_CRC_HI,  8'h00, 1'b0, 1'b0, EV_PAYLOAD,  8'h00, 16'h0000},
        '{SEND_RAW,     8'h00, 1'b0, 1'b1, EV_NO_END,   8'h00, 16'h0002}
    };

    crc_framed_packet_receiver_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // bit-serial form of the reflected 0xA001 update
    function automatic logic [15:0] crc16_modbus_next(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = r[0] ^ data[i];
            r = r >> 1;
            if (fb)
                r = r ^ 16'hA001;
        end
        return r;
    endfunction

    task automatic bump_rejects();
        if (reject_total != COUNT_MAX)
            reject_total = reject_total + 16'd1;
    endtask

    task automatic predict_rx(input logic [7:0] b, input logic idle,
                              output logic got, output result_t ev);
        got = 1'b0;
        ev = '0;
        if (idle)
            rx_phase = PH_HUNT_A;
        else
        begin
            case (rx_phase)
                PH_HUNT_B:
                begin
                    if (b == START_BYTE_B)
                    begin
                        crc_run = crc16_modbus_next(crc_run, b);
                        rx_phase = PH_LEN;
                    end
                    else if (b == START_BYTE_A)
                    begin
                        crc_run = crc16_modbus_next(CRC_INIT, START_BYTE_A);
                        rx_phase = PH_HUNT_B;
                    end
                    else
                        rx_phase = PH_HUNT_A;
                end
                PH_LEN:
                begin
                    frame_len = b;
                    crc_run = crc16_modbus_next(crc_run, b);
                    pay_count = 8'h00;
                    if (b > len_limit)
                    begin
                        bump_rejects();
                        rx_phase = PH_HUNT_A;
                        got = 1'b1;
                        ev.event_kind = EV_OVERSIZE;
                    end
                    else
                        rx_phase = (b == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    got = 1'b1;
                    ev.event_kind = EV_PAYLOAD;
                    ev.payload_byte = b;
                    ev.payload_index = pay_count;
                    crc_run = crc16_modbus_next(crc_run, b);
                    pay_count = pay_count + 8'd1;
                    if (pay_count == frame_len)
                        rx_phase = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    crc_lo_byte = b;
                    rx_phase = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    // zero left over means the sent crc matched
                    crc_run = crc_run ^ {b, crc_lo_byte};
                    rx_phase = PH_END;
                end
                PH_END:
                begin
                    rx_phase = PH_HUNT_A;
                    got = 1'b1;
                    if (b != END_BYTE)
                        ev.event_kind = EV_NO_END;
                    else if (check_crc && crc_run != 16'h0000)
                    begin
                        bump_rejects();
                        ev.event_kind = EV_CRC_BAD;
                    end
                    else
                        ev.event_kind = EV_ACCEPT;
                end
                default:
                begin
                    if (b == START_BYTE_A)
                    begin
                        crc_run = crc16_modbus_next(CRC_INIT, START_BYTE_A);
                        rx_phase = PH_HUNT_B;
                    end
                    else
                        rx_phase = PH_HUNT_A;
                end
            endcase
        end
        if (got)
        begin
            ev.frame_length = frame_len;
            ev.invalid_count = reject_total;
        end
    endtask

    // one byte transfer on the input side, with random gaps in front unless steady
    task automatic put_byte(input logic [7:0] b, input logic idle);
        logic    got;
        result_t ev;
        while (!steady && $urandom_range(0, 99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= idle;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        items_done++;
        predict_rx(b, idle, got, ev);
        if (pin_due)
            events_due.push_back(pin_event);
        else if (got)
            events_due.push_back(ev);
        pin_due = 1'b0;
    endtask

    // stop sending, let every event come out and the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regs(input logic en, input logic [7:0] lim);
        wr_en <= 1'b1;
        wr_index <= REG_CRC_CHECK_ENABLE;
        wr_data <= {7'b0, en};
        @(posedge clk);
        wr_index <= REG_MAX_PAYLOAD_LEN;
        wr_data <= lim;
        @(posedge clk);
        wr_en <= 1'b0;
        check_crc = en;
        len_limit = lim;
    endtask

    // mostly whole frames with random content, the rest line noise
    task automatic random_burst();
        int unsigned len;
        int unsigned n;
        int unsigned cut;
        logic [7:0]  b;
        if ($urandom_range(0, 99) < 75)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(0, 255);
            else if ($urandom_range(0, 29) == 0)
                len = len_limit;
            else
                len = $urandom_range(0, (len_limit < 12) ? len_limit : 12);
            n = (len > len_limit) ? 3 : len + 6;
            cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : n;
            if ($urandom_range(0, 9) == 0)
                put_byte(START_BYTE_A, 1'b0);
            for (int unsigned i = 0; i < n; i++)
            begin
                if (i == cut)
                    put_byte(8'($urandom_range(0, 255)), 1'b1);
                if (i == 0)
                    b = START_BYTE_A;
                else if (i == 1)
                    b = START_BYTE_B;
                else if (i == 2)
                    b = len[7:0];
                else if (i < len + 3)
                    b = 8'($urandom_range(0, 255));
                else if (i == len + 3)
                    b = crc_run[7:0];
                else if (i == len + 4)
                    b = ($urandom_range(0, 9) == 0) ?
                        crc_run[15:8] ^ 8'($urandom_range(1, 255)) : crc_run[15:8];
                else
                    b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : END_BYTE;
                put_byte(b, 1'b0);
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0: b = START_BYTE_A;
                    1: b = START_BYTE_B;
                    2: b = END_BYTE;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                put_byte(b, $urandom_range(0, 7) == 0);
            end
        end
    endtask

    task automatic field_check(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 14);

    // inputs only move at the rising edge, so the falling-edge view is what the edge takes
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (events_due.size() == 0)
            begin
                $error("event transfer with nothing expected: kind %0d", m_tuser);
                mismatches++;
            end
            else
            begin
                want = events_due.pop_front();
                field_check("event_kind", 16'(want.event_kind), 16'(m_tuser));
                field_check("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]));
                field_check("payload_index", 16'(want.payload_index), 16'(m_tdata[15:8]));
                field_check("frame_length", 16'(want.frame_length), 16'(m_tdata[23:16]));
                field_check("invalid_count", want.invalid_count, m_tdata[39:24]);
            end
        end
    end

    initial
    begin
        logic [7:0]  b;
        int unsigned goal;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            case (dir_rows[k].how)
                SEND_CRC_LO:  b = crc_run[7:0];
                SEND_CRC_HI:  b = crc_run[15:8];
                SEND_CRC_BAD: b = crc_run[15:8] ^ 8'h01;
                default:      b = dir_rows[k].value;
            endcase
            pin_event = '0;
            pin_event.event_kind = dir_rows[k].ev;
            pin_event.frame_length = dir_rows[k].flen;
            pin_event.invalid_count = dir_rows[k].cnt;
            pin_due = dir_rows[k].pinned;
            put_byte(b, dir_rows[k].idle);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            if (ph > 0)
                set_regs(phase_crc[ph], phase_len[ph]);
            steady = (ph == 1);
            goal = items_done + 260;
            while (items_done < goal)
                random_burst();
        end
        steady = 1'b0;

        // crc failures and oversize frames under a short length limit
        settle();
        set_regs(1'b1, 8'd20);
        goal = items_done + 200;
        while (items_done < goal)
            random_burst();

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
